FILE: src/sq_pkg.sv
// Shared types, constants and helper functions for the sample quantizer.
// No dependencies; every other file refers to it by scoped names.
package sq_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int CODE_WIDTH   = 32;
  localparam int NSTAGE       = 7;
  // Fixed-point width of |product +/- 0.5| with 25 fraction bits.
  localparam int FIX_W        = 58;

  typedef enum logic {
    MODE_INT   = 1'b0,
    MODE_FLOAT = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_SHIFT = 2'd1,
    REG_SCALE = 2'd2,
    REG_CODE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } flow_t;

  typedef struct packed {
    logic              sgn;
    logic signed [9:0] exp;
    logic [23:0]       man;
    logic              zero;
    logic              inf;
    logic              nan;
  } fp_t;

  // Unpack IEEE single; subnormals come back normalized with hidden bit at 23.
  function automatic fp_t fp_unpack(logic [31:0] b);
    fp_t        f;
    logic [23:0] m0;
    logic [4:0]  pos;
    logic [4:0]  lz;
    f.sgn  = b[31];
    f.zero = (b[30:0] == 31'd0);
    f.inf  = (&b[30:23]) && (b[22:0] == 23'd0);
    f.nan  = (&b[30:23]) && (|b[22:0]);
    m0     = {1'b0, b[22:0]};
    pos    = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m0[i]) pos = 5'(i);
    end
    lz = 5'd23 - pos;
    if (b[30:23] != 8'd0) begin
      f.man = {1'b1, b[22:0]};
      f.exp = $signed({2'b00, b[30:23]}) - 10'sd127;
    end else begin
      f.man = m0 << lz;
      f.exp = -10'sd126 - $signed({5'b00000, lz});
    end
    return f;
  endfunction

  // Code width as used: zero means one, anything above 32 means 32.
  function automatic logic [5:0] eff_width(logic [5:0] cb);
    logic [5:0] w;
    if (cb == 6'd0) w = 6'd1;
    else if (cb > 6'd32) w = 6'd32;
    else w = cb;
    return w;
  endfunction

  // Keep the low w bits and sign-extend them to 32 bits.
  function automatic logic [31:0] sext_code(logic [31:0] v, logic [5:0] w);
    logic [5:0]  sh;
    logic [31:0] t;
    sh = 6'd32 - w;
    t  = v << sh;
    return $unsigned($signed(t) >>> sh);
  endfunction

endpackage

FILE: src/sq_flow.sv
// Valid chain and per-stage load enables for the quantizer pipeline.
// Depends on sq_pkg (stage count, flow_t).
module sq_flow (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_ready,
  output logic          in_ready,
  output sq_pkg::flow_t flow
);

  logic [sq_pkg::NSTAGE-1:0] vld;
  logic [sq_pkg::NSTAGE-1:0] en;

  // A stage loads when it is empty or its holder moves on.
  always_comb begin
    en[sq_pkg::NSTAGE-1] = !vld[sq_pkg::NSTAGE-1] || out_ready;
    for (int i = sq_pkg::NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < sq_pkg::NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign flow.en  = en;
  assign flow.vld = vld;

`ifndef SYNTH
  // Items in flight change only by transfers at the two ends.
  a_count : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(vld) == $past($countones(vld))
      + $past(in_valid && en[0]) - $past(vld[sq_pkg::NSTAGE-1] && out_ready)))
    else $error("pipeline occupancy mismatch");
  // An empty output stage never back-pressures the input.
  a_empty_out : assert property (@(posedge clk) disable iff (rst)
    !vld[sq_pkg::NSTAGE-1] |-> in_ready)
    else $error("input stalled with empty output stage");
  // A full pipeline with a stalled output refuses input.
  a_full : assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !out_ready) |-> !in_ready)
    else $error("full pipeline accepted input");
`endif

endmodule

FILE: src/sample_quantizer.sv
// Top level of the sample quantizer: config registers and the 7-stage datapath.
// Depends on sq_pkg and sq_flow.
//
//  channel | signals                          | contents
//  --------+----------------------------------+------------------------------------
//  in      | s_tvalid s_tready s_tdata[31:0]  | sample
//  out     | m_tvalid m_tready m_tdata[31:0]  | code; m_tuser[0] out_of_range
//  config  | cfg_we cfg_index[1:0] cfg_data   | mode, shift_bits, scale_factor, code_bits
//
// One sample per cycle sustained while the output is not stalled; each result
// is registered in stages 0 to 6 in turn and presented from the last. The depth is
// set by the float path (unpack, 24x24 multiply, product rounding, +/-0.5
// alignment, sum rounding, truncation, range check).
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// A stall on the output holds the last stage and backs up only as far as
// there are no bubbles; nothing is dropped or repeated.
module sample_quantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] code
  output logic [0:0]  m_tuser,   // [0] out_of_range
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  sq_pkg::flow_t flow;

  sq_flow u_flow (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_ready(m_tready),
    .in_ready (s_tready),
    .flow     (flow)
  );

  // ---------------- configuration ----------------
  sq_pkg::mode_t mode;
  logic [4:0]    shift_bits;
  logic [31:0]   scale_factor;
  logic [5:0]    code_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= sq_pkg::MODE_FLOAT;
      shift_bits   <= 5'd0;
      scale_factor <= 32'h3F80_0000;
      code_bits    <= 6'd32;
    end else if (cfg_we) begin
      case (sq_pkg::reg_idx_t'(cfg_index))
        sq_pkg::REG_MODE:  mode         <= sq_pkg::mode_t'(cfg_data[0]);
        sq_pkg::REG_SHIFT: shift_bits   <= cfg_data[4:0];
        sq_pkg::REG_SCALE: scale_factor <= cfg_data;
        sq_pkg::REG_CODE:  code_bits    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: unpack, integer bias ----------------
  sq_pkg::fp_t fx, fs;
  logic [31:0] bias;

  logic              p0_bad, p0_xzero, p0_pzero, p0_sh, p0_sp;
  logic [23:0]       p0_mx, p0_ms;
  logic signed [9:0] p0_e;
  logic [31:0]       p0_word;

  always_comb begin
    fx   = sq_pkg::fp_unpack(s_tdata);
    fs   = sq_pkg::fp_unpack(scale_factor);
    bias = s_tdata[31] ? ((32'd1 << shift_bits) - 32'd1) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (flow.en[0]) begin
      // NaN sample, or a nonzero sample meeting an infinite or NaN operand.
      p0_bad   <= fx.nan || (!fx.zero && (fx.inf || fs.inf || fs.nan));
      p0_xzero <= fx.zero;
      p0_pzero <= fs.zero;
      p0_sh    <= fx.sgn;
      p0_sp    <= fx.sgn ^ fs.sgn;
      p0_mx    <= fx.man;
      p0_ms    <= fs.man;
      p0_e     <= fx.exp + fs.exp;
      p0_word  <= s_tdata + bias;
    end
  end

  // ---------------- stage 1: multiply, integer shift ----------------
  logic              p1_bad, p1_xzero, p1_pzero, p1_sh, p1_sp;
  logic [47:0]       p1_prod;
  logic signed [9:0] p1_e;
  logic [31:0]       p1_word;

  always_ff @(posedge clk) begin
    if (flow.en[1]) begin
      p1_bad   <= p0_bad;
      p1_xzero <= p0_xzero;
      p1_pzero <= p0_pzero;
      p1_sh    <= p0_sh;
      p1_sp    <= p0_sp;
      p1_prod  <= 48'(p0_mx) * 48'(p0_ms);
      p1_e     <= p0_e;
      p1_word  <= $unsigned($signed(p0_word) >>> shift_bits);
    end
  end

  // ---------------- stage 2: round product to single ----------------
  logic signed [10:0] r_e;
  logic [23:0]        r_m;
  logic               r_g, r_st, r_up;
  logic [24:0]        r_sum;
  logic [23:0]        r_man;
  logic signed [10:0] r_exp;
  logic               r_tiny, r_big;

  always_comb begin
    if (p1_prod[47]) begin
      r_m  = p1_prod[47:24];
      r_g  = p1_prod[23];
      r_st = |p1_prod[22:0];
      r_e  = 11'(p1_e) + 11'sd1;
    end else begin
      r_m  = p1_prod[46:23];
      r_g  = p1_prod[22];
      r_st = |p1_prod[21:0];
      r_e  = 11'(p1_e);
    end
    r_up  = r_g && (r_st || r_m[0]);
    r_sum = {1'b0, r_m} + 25'(r_up);
    if (r_sum[24]) begin
      r_man = r_sum[24:1];
      r_exp = r_e + 11'sd1;
    end else begin
      r_man = r_sum[23:0];
      r_exp = r_e;
    end
    // Below a quarter the +/-0.5 step decides alone: treat as zero product.
    r_tiny = p1_pzero || (r_exp <= -11'sd3);
    r_big  = !p1_pzero && (r_exp >= 11'sd32);
  end

  logic        p2_bad, p2_xzero, p2_tiny, p2_sh, p2_sp;
  logic [23:0] p2_man;
  logic [5:0]  p2_ep;
  logic [31:0] p2_word;

  always_ff @(posedge clk) begin
    if (flow.en[2]) begin
      p2_bad   <= p1_bad || (r_big && !p1_xzero);
      p2_xzero <= p1_xzero;
      p2_tiny  <= r_tiny;
      p2_sh    <= p1_sh;
      p2_sp    <= p1_sp;
      p2_man   <= r_man;
      p2_ep    <= (r_tiny || r_big) ? 6'd0 : 6'(r_exp + 11'sd2);
      p2_word  <= p1_word;
    end
  end

  // ---------------- stage 3: exact p +/- 0.5 in fixed point ----------------
  logic [sq_pkg::FIX_W-1:0] a_pm, a_half, a_f;
  logic                     a_sr;

  always_comb begin
    a_half = sq_pkg::FIX_W'(1) << 24;
    a_pm   = p2_tiny ? '0 : (sq_pkg::FIX_W'(p2_man) << p2_ep);
    if (p2_xzero) begin
      a_f  = '0;
      a_sr = 1'b0;
    end else if (p2_sp == p2_sh) begin
      a_f  = a_pm + a_half;
      a_sr = p2_sp;
    end else if (a_pm >= a_half) begin
      a_f  = a_pm - a_half;
      a_sr = p2_sp;
    end else begin
      a_f  = a_half - a_pm;
      a_sr = p2_sh;
    end
  end

  logic                     p3_bad, p3_sr;
  logic [sq_pkg::FIX_W-1:0] p3_f;
  logic [5:0]               p3_ep;
  logic [31:0]              p3_word;

  always_ff @(posedge clk) begin
    if (flow.en[3]) begin
      p3_bad  <= p2_bad;
      p3_sr   <= a_sr;
      p3_f    <= a_f;
      p3_ep   <= p2_ep;
      p3_word <= p2_word;
    end
  end

  // ---------------- stage 4: pick rounding point of the sum ----------------
  logic [5:0]               n_i1, n_i0, n_d;
  logic [sq_pkg::FIX_W-1:0] n_mask;
  logic                     n_g, n_st, n_lsb, n_up;

  always_comb begin
    n_i1 = p3_ep + 6'd24;
    n_i0 = p3_ep + 6'd23;
    if (p3_f[n_i1]) n_d = p3_ep + 6'd1;
    else if (p3_f[n_i0]) n_d = p3_ep;
    else n_d = (p3_ep == 6'd0) ? 6'd0 : p3_ep - 6'd1;
    n_mask = (sq_pkg::FIX_W'(1) << n_d) - sq_pkg::FIX_W'(1);
    n_g    = |(p3_f & (n_mask ^ (n_mask >> 1)));
    n_st   = |(p3_f & (n_mask >> 1));
    n_lsb  = |(p3_f & (sq_pkg::FIX_W'(1) << n_d));
    n_up   = n_g && (n_st || n_lsb);
  end

  logic                     p4_bad, p4_sr, p4_up;
  logic [sq_pkg::FIX_W-1:0] p4_q;
  logic [5:0]               p4_d;
  logic [31:0]              p4_word;

  always_ff @(posedge clk) begin
    if (flow.en[4]) begin
      p4_bad  <= p3_bad;
      p4_sr   <= p3_sr;
      p4_up   <= n_up;
      p4_q    <= p3_f >> n_d;
      p4_d    <= n_d;
      p4_word <= p3_word;
    end
  end

  // ---------------- stage 5: rebuild rounded value, truncate ----------------
  logic [sq_pkg::FIX_W:0] t_r;

  always_comb begin
    t_r = (59'(p4_q) + 59'(p4_up)) << p4_d;
  end

  logic        p5_bad, p5_sr, p5_frac;
  logic [33:0] p5_t;
  logic [31:0] p5_word;

  always_ff @(posedge clk) begin
    if (flow.en[5]) begin
      p5_bad  <= p4_bad;
      p5_sr   <= p4_sr;
      p5_frac <= |t_r[24:0];
      p5_t    <= t_r[58:25];
      p5_word <= p4_word;
    end
  end

  // ---------------- stage 6: range check, output register ----------------
  logic [5:0]  o_w;
  logic [33:0] o_lim;
  logic        o_bad;
  logic [31:0] o_val;
  logic [31:0] o_code;
  logic        o_oor;

  always_comb begin
    o_w   = sq_pkg::eff_width(code_bits);
    o_lim = 34'd1 << (o_w - 6'd1);
    if (p5_sr) begin
      o_bad = p5_bad || (p5_t > o_lim) || ((p5_t == o_lim) && p5_frac);
      o_val = 32'(34'd0 - p5_t);
    end else begin
      o_bad = p5_bad || (p5_t >= o_lim) || ((p5_t == (o_lim - 34'd1)) && p5_frac);
      o_val = p5_t[31:0];
    end
    if (mode == sq_pkg::MODE_INT) begin
      o_code = sq_pkg::sext_code(p5_word, o_w);
      o_oor  = 1'b0;
    end else if (o_bad) begin
      o_code = 32'd0;
      o_oor  = 1'b1;
    end else begin
      o_code = sq_pkg::sext_code(o_val, o_w);
      o_oor  = 1'b0;
    end
  end

  logic [31:0] p6_code;
  logic        p6_oor;

  always_ff @(posedge clk) begin
    if (flow.en[6]) begin
      p6_code <= o_code;
      p6_oor  <= o_oor;
    end
  end

  assign m_tvalid   = flow.vld[sq_pkg::NSTAGE-1];
  assign m_tdata    = p6_code;
  assign m_tuser[0] = p6_oor;

`ifndef SYNTH
  // Range flags come only from the float path.
  a_oor_mode : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (mode == sq_pkg::MODE_FLOAT))
    else $error("out_of_range in integer mode");
  // A flagged result carries a zero code.
  a_oor_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
    else $error("flagged result with nonzero code");
  // One-bit code width gives only 0 or -1.
  a_w1 : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (code_bits == 6'd1)) |-> ((m_tdata == 32'd0) || (&m_tdata)))
    else $error("code not sign-extended from one bit");
`endif

endmodule

FILE: test/sample_quantizer_tb.sv
// Self-checking testbench for sample_quantizer: directed and random samples in
// both modes, random stalls on both streams. Depends on sq_pkg and the RTL.
module sample_quantizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] code;
    logic        oor;
  } quant_result_t;

  // Scoreboard: mirrors the registers, predicts each code, checks in order.
  class quant_scoreboard;
    sq_pkg::mode_t mode;
    logic [4:0]    shift;
    logic [31:0]   scale;
    logic [5:0]    cbits;
    quant_result_t pending[$];
    int            errors;

    function new();
      mode   = sq_pkg::MODE_FLOAT;
      shift  = 5'd0;
      scale  = 32'h3F80_0000;
      cbits  = 6'd32;
      errors = 0;
    endfunction

    function int width_used();
      if (cbits == 6'd0) return 1;
      if (cbits > 6'd32) return 32;
      return int'(cbits);
    endfunction

    // Keep low w bits, replicate bit w-1 upward.
    function logic [31:0] sign_fill(logic [31:0] v, int w);
      logic [31:0] r;
      r = v;
      for (int i = w; i < 32; i++) r[i] = v[w-1];
      return r;
    endfunction

    function int bit_len(logic [127:0] v);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
      return n;
    endfunction

    function real pow2(int e);
      logic [10:0] be;
      be = 11'(e + 1023);
      return $bitstoreal({1'b0, be, 52'd0});
    endfunction

    // Magnitude of a finite nonzero single, exact in double.
    function real single_mag(logic [31:0] b);
      if (b[30:23] == 8'd0) return real'(b[22:0]) * pow2(-149);
      return real'({1'b1, b[22:0]}) * pow2(int'(b[30:23]) - 150);
    endfunction

    function quant_result_t quantize_float(logic [31:0] x);
      quant_result_t res;
      logic        neg, half_oor;
      logic [63:0] dbits, dm, rem, half, q;
      logic [127:0] fx, sum, m, lim, rem2, half2;
      int          de, sh, ex, len, d, w;
      real         prod;
      res.code = '0;
      res.oor  = 1'b0;
      w = width_used();
      neg = x[31] ^ scale[31];
      // A product too small to matter leaves +/-0.5 with the sample's sign;
      // a one-bit code cannot hold +0.5.
      half_oor = !x[31] && (w == 1);
      if ((&x[30:23]) && (|x[22:0])) begin
        res.oor = 1'b1;                       // NaN sample
        return res;
      end
      if (x[30:0] == 31'd0) return res;       // zero sample gives zero
      if ((&x[30:23]) || (&scale[30:23])) begin
        res.oor = 1'b1;                       // infinite or NaN product
        return res;
      end
      if (scale[30:0] == 31'd0) begin
        res.oor = half_oor;                   // zero product leaves +/-0.5
        return res;
      end
      // Exact product in double, then round to single (nearest, ties even).
      prod  = single_mag(x) * single_mag(scale);
      dbits = $realtobits(prod);
      de    = int'(dbits[62:52]) - 1023;
      dm    = {11'd0, 1'b1, dbits[51:0]};
      sh    = (de >= -126) ? 29 : 29 + (-126 - de);
      if (sh >= 60) begin
        res.oor = half_oor;
        return res;
      end
      q    = dm >> sh;
      rem  = dm & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      ex  = de - 52 + sh;
      if (q == 64'd0) begin
        res.oor = half_oor;
        return res;
      end
      len = bit_len(128'(q));
      if (ex + len > 128) begin
        res.oor = 1'b1;                       // product overflows to infinity
        return res;
      end
      if (ex + len <= -26) begin
        res.oor = half_oor;                   // sum rounds to exactly 0.5
        return res;
      end
      if (ex + len > 40) begin
        res.oor = 1'b1;
        return res;
      end
      // Fixed point with 64 fraction bits; add or take off half by the sign.
      fx = 128'(q) << (ex + 64);
      if (!scale[31]) begin
        sum = fx + (128'd1 << 63);
      end else if (fx >= (128'd1 << 63)) begin
        sum = fx - (128'd1 << 63);
      end else begin
        sum = (128'd1 << 63) - fx;
        neg = x[31];
      end
      len = bit_len(sum);
      m   = sum;
      if (len > 24) begin
        d     = len - 24;
        rem2  = sum & ((128'd1 << d) - 128'd1);
        half2 = 128'd1 << (d - 1);
        m     = sum >> d;
        if (rem2 > half2 || (rem2 == half2 && m[0])) m = m + 128'd1;
        m = m << d;
      end
      if (neg) lim = 128'd1 << (w - 1 + 64);
      else     lim = ((128'd1 << (w - 1)) - 128'd1) << 64;
      if (m > lim) begin
        res.oor = 1'b1;
        return res;
      end
      m = m >> 64;
      res.code = sign_fill(neg ? (~m[31:0] + 32'd1) : m[31:0], w);
      return res;
    endfunction

    function quant_result_t quantize(logic [31:0] smp);
      quant_result_t res;
      longint        v;
      if (mode == sq_pkg::MODE_INT) begin
        v = longint'($signed(smp)) / (64'sd1 <<< shift);
        res.code = sign_fill(v[31:0], width_used());
        res.oor  = 1'b0;
      end else begin
        res = quantize_float(smp);
      end
      return res;
    endfunction

    function void note_sample(logic [31:0] smp);
      pending.push_back(quantize(smp));
    endfunction

    function void check_result(logic [31:0] code, logic oor);
      quant_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result code=%h oor=%b", $time, code, oor);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (code !== exp_r.code) begin
        $display("%0t: code expected %h actual %h", $time, exp_r.code, code);
        errors++;
      end
      if (oor !== exp_r.oor) begin
        $display("%0t: out_of_range expected %b actual %b", $time, exp_r.oor, oor);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] sample
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] code
  logic [0:0]  m_tuser;   // [0] out_of_range
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  quant_scoreboard quant_sb = new();
  bit              idle_on;
  int unsigned     cycles;

  localparam int unsigned CYCLE_LIMIT = 300000;

  sample_quantizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watch both streams at the rising edge; predict on input, check on output.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) quant_sb.note_sample(s_tdata);
    if (!rst && m_tvalid && m_tready) quant_sb.check_result(m_tdata, m_tuser[0]);
  end

  // Watchdog: bail out if the pipeline hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sample_quantizer_tb failed");
      $finish;
    end
  end

  // Result side: stall in random bursts while idling is on.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Offer one sample; return at the falling edge after its transfer.
  task automatic send_sample(input logic [31:0] smp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input sq_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sq_pkg::REG_MODE:  quant_sb.mode  = sq_pkg::mode_t'(val[0]);
      sq_pkg::REG_SHIFT: quant_sb.shift = val[4:0];
      sq_pkg::REG_SCALE: quant_sb.scale = val;
      default:           quant_sb.cbits = val[5:0];
    endcase
    @(negedge clk);
  endtask

  // Hold until every expected code is back, then let the pipe settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (quant_sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [31:0] random_sample(sq_pkg::mode_t md);
    logic [31:0] v;
    int          pick;
    pick = $urandom_range(0, 9);
    v = $urandom;
    if (md == sq_pkg::MODE_INT) begin
      if (pick < 3) v = 32'($signed(16'($urandom)));
      return v;
    end
    if (pick < 7) begin
      v[30:23] = 8'($urandom_range(97, 165));   // magnitudes from 2^-30 up to below 2^39
    end else if (pick == 7) begin
      case ($urandom_range(0, 4))
        0: v = 32'h0000_0000;
        1: v = 32'h8000_0000;
        2: v = {v[31], 8'hFF, 23'd0};
        3: v = {v[31], 8'hFF, v[22:0] | 23'd1};
        default: v = {v[31], 8'h00, v[22:0]};
      endcase
    end
    return v;
  endfunction

  logic [31:0] directed_float[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3FC0_0000,
    32'hC020_0000, 32'h3F00_0000, 32'h3EFF_FFFF, 32'h7FC0_0000, 32'hFFFF_FFFF,
    32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0001,
    32'h4F00_0000, 32'hCF00_0000, 32'h4EFF_FFFF, 32'h4B7F_FFFF, 32'h7FFF_FFFF
  };
  logic [31:0] directed_int[] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'hFFFF_FFF9
  };
  logic [31:0] phase_scale[] = '{
    32'h3F80_0000, 32'h0000_0000, 32'h7F80_0000, 32'h7FC0_0000, 32'h0000_0001,
    32'hFFFF_FFFF, 32'h3A83_126F, 32'h4B00_0000, 32'hBF00_0000, 32'h4700_0000,
    32'h3DCC_CCCD, 32'hC2C8_0000
  };
  int phase_shift[] = '{0, 31, 5, 16, 1, 30, 8, 12, 3, 20, 7, 0};
  int phase_code[]  = '{32, 1, 0, 8, 16, 63, 33, 24, 12, 31, 2, 32};

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = sq_pkg::REG_MODE;
    cfg_data  = '0;
    idle_on   = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset defaults are float mode, unit scale, 32-bit codes.
    foreach (directed_float[i]) send_sample(directed_float[i]);
    drain();
    write_reg(sq_pkg::REG_MODE, 32'(sq_pkg::MODE_INT));
    write_reg(sq_pkg::REG_SHIFT, 32'd31);
    write_reg(sq_pkg::REG_CODE, 32'd4);
    foreach (directed_int[i]) send_sample(directed_int[i]);
    drain();

    // Random phases, each with every register rewritten.
    foreach (phase_scale[p]) begin
      sq_pkg::mode_t md;
      md = sq_pkg::mode_t'(p % 2 == 0);
      if (p >= 10) idle_on = 1'b0;
      write_reg(sq_pkg::REG_MODE, 32'(md));
      write_reg(sq_pkg::REG_SHIFT, 32'(phase_shift[p]));
      write_reg(sq_pkg::REG_SCALE, (p == 11) ? 32'($urandom) : phase_scale[p]);
      write_reg(sq_pkg::REG_CODE, 32'(phase_code[p]));
      repeat (48) send_sample(random_sample(md));
      drain();
    end

    repeat (20) @(posedge clk);
    if (quant_sb.errors == 0 && quant_sb.pending.size() == 0) begin
      $display("sample_quantizer_tb passed");
    end else begin
      $display("sample_quantizer_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sq_pkg.sv
src/sq_flow.sv
src/sample_quantizer.sv
test/sample_quantizer_tb.sv
